### rtl/ppo_pkg.sv
`default_nettype none

package ppo_pkg;

    localparam int CHAN_W  = 8;
    localparam int PARAM_W = 18;
    localparam int MODE_W  = 3;
    localparam int PIX_W   = 4 * CHAN_W;

    // wide enough for chan * param and chan * 256 + param
    localparam int VAL_W   = CHAN_W + PARAM_W + 1;

    // sum of three channels and 1/3 reciprocal scaling
    localparam int SUM_W   = CHAN_W + 2;
    localparam int RECIP_N = 683;
    localparam int RECIP_S = 11;
    localparam int SCL_W   = 21;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_PARAM = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 3'd0,
        MODE_GAIN = 3'd1,
        MODE_G2A  = 3'd2,
        MODE_GRAY = 3'd3,
        MODE_THR  = 3'd4,
        MODE_PASS = 3'd5
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [PARAM_W-1:0] param;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/ppo_lane.sv
`default_nettype none

module ppo_lane (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire ppo_pkg::t_cfg         i_cfg,
    input  wire logic [7:0]            i_chan,
    output logic [7:0]                 o_chan
);
    import ppo_pkg::*;

    logic signed [VAL_W-1:0] w_c_ext;
    logic signed [VAL_W-1:0] w_p_ext;
    logic signed [VAL_W-1:0] w_sum;
    logic signed [VAL_W-1:0] w_prod;
    logic signed [VAL_W-1:0] n_value;
    logic signed [VAL_W-1:0] r_value;

    // offset or gain in q.8, one multiplier per lane
    assign w_c_ext = $signed(VAL_W'({1'b0, i_chan}));
    assign w_p_ext = VAL_W'(i_cfg.param);
    assign w_sum   = (w_c_ext <<< CHAN_W) + w_p_ext;
    assign w_prod  = w_c_ext * w_p_ext;
    assign n_value = (i_cfg.mode == MODE_GAIN) ? w_prod : w_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
        end
    end

    // truncate toward zero and clamp to 0..255
    always_comb begin
        if (r_value <= 0) begin
            o_chan = '0;
        end else if (r_value[VAL_W-2:2*CHAN_W] != '0) begin
            o_chan = CHAN_MAX;
        end else begin
            o_chan = r_value[2*CHAN_W-1:CHAN_W];
        end
    end

endmodule

`default_nettype wire

### rtl/ppo_gray.sv
`default_nettype none

module ppo_gray (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire ppo_pkg::t_cfg         i_cfg,
    input  wire logic [7:0]            i_chan0,
    input  wire logic [7:0]            i_chan1,
    input  wire logic [7:0]            i_chan2,
    output logic [7:0]                 o_avg,
    output logic                       o_above
);
    import ppo_pkg::*;

    logic [SUM_W-1:0]  r_sum;
    logic [SCL_W-1:0]  w_scaled;
    logic              w_corr;
    logic signed [SUM_W:0] w_thr;

    // channel sum registered with the lanes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= SUM_W'(i_chan0) + SUM_W'(i_chan1) + SUM_W'(i_chan2);
        end
    end

    // divide by three through a reciprocal, exact for sums up to 765
    assign w_scaled = SCL_W'(r_sum) * SCL_W'(RECIP_N);
    assign o_avg    = w_scaled[RECIP_S+CHAN_W-1:RECIP_S];

    // integer part of the parameter, rounded toward zero
    assign w_corr = i_cfg.param[PARAM_W-1] && (i_cfg.param[CHAN_W-1:0] != '0);
    assign w_thr  = $signed((SUM_W+1)'(i_cfg.param >>> CHAN_W))
                  + $signed({{SUM_W{1'b0}}, w_corr});

    assign o_above = $signed({{(SUM_W+1-CHAN_W){1'b0}}, o_avg}) > w_thr;

endmodule

`default_nettype wire

### rtl/pixel_point_operation.sv
`default_nettype none

// an accepted request passes through stage 1 and then the output register before output valid
// throughput: one pixel per cycle while the output side does not stall
// a finished pixel waits in the output register while the next is taken in
// reset (synchronous, active low) empties the pipeline, mode to pass-through, param to 0
module pixel_point_operation (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic         i_cfg_addr,
    input  wire logic [17:0]  i_cfg_data,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // chan0_in[7:0], chan1_in[15:8], chan2_in[23:16], alpha_in[31:24]
    input  wire logic [31:0]  i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // chan0_out[7:0], chan1_out[15:8], chan2_out[23:16], alpha_out[31:24]
    output logic [31:0]       o_m_axis_tdata
);
    import ppo_pkg::*;

    t_cfg               r_cfg;
    logic               r_v1;
    logic [PIX_W-1:0]   r_pix1;
    logic               r_v2;
    logic [PIX_W-1:0]   r_pix2;
    logic [PIX_W-1:0]   n_pix2;
    logic               w_en1;
    logic               w_en2;
    logic [CHAN_W-1:0]  w_lane [3];
    logic [CHAN_W-1:0]  w_avg;
    logic               w_above;
    logic [CHAN_W-1:0]  w_bin;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= MODE_PASS;
            r_cfg.param <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_MODE:  r_cfg.mode  <= i_cfg_data[MODE_W-1:0];
                CFG_PARAM: r_cfg.param <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // stage enables, each stage moves when the stage after it frees up
    assign w_en2           = !r_v2 || i_m_axis_tready;
    assign w_en1           = !r_v1 || w_en2;
    assign o_s_axis_tready = w_en1;

    // colour lanes
    for (genvar g = 0; g < 3; g++) begin : g_lane
        ppo_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en1),
            .i_cfg  (r_cfg),
            .i_chan (i_s_axis_tdata[g*CHAN_W +: CHAN_W]),
            .o_chan (w_lane[g])
        );
    end

    // gray average and threshold
    ppo_gray u_gray (
        .i_clk   (i_clk),
        .i_en    (w_en1),
        .i_cfg   (r_cfg),
        .i_chan0 (i_s_axis_tdata[0*CHAN_W +: CHAN_W]),
        .i_chan1 (i_s_axis_tdata[1*CHAN_W +: CHAN_W]),
        .i_chan2 (i_s_axis_tdata[2*CHAN_W +: CHAN_W]),
        .o_avg   (w_avg),
        .o_above (w_above)
    );

    // stage 1 keeps the raw pixel for pass-through and alpha
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_pix1 <= i_s_axis_tdata;
        end
    end

    // merge lanes and gray path by mode
    assign w_bin = w_above ? CHAN_MAX : '0;

    always_comb begin
        case (r_cfg.mode) inside
            MODE_ADD, MODE_GAIN: begin
                n_pix2 = {r_pix1[3*CHAN_W +: CHAN_W], w_lane[2], w_lane[1], w_lane[0]};
            end
            MODE_G2A: begin
                n_pix2 = {w_avg, r_pix1[3*CHAN_W-1:0]};
            end
            MODE_GRAY: begin
                n_pix2 = {r_pix1[3*CHAN_W +: CHAN_W], w_avg, w_avg, w_avg};
            end
            MODE_THR: begin
                n_pix2 = {r_pix1[3*CHAN_W +: CHAN_W], w_bin, w_bin, w_bin};
            end
            default: begin
                n_pix2 = r_pix1;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_pix2 <= n_pix2;
        end
    end

    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = r_pix2;

    // an accepted request lands in stage 1
    a_in_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v1)
        else $error("accepted request lost before stage 1");

    // stage 1 moves into the output register when it is free
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && w_en2) |=> o_m_axis_tvalid)
        else $error("stage 1 request lost before output");

    // a stalled result is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("stalled result dropped");

    // gray and threshold give three equal colours
    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_cfg.mode == MODE_GRAY || r_cfg.mode == MODE_THR)) |->
        (o_m_axis_tdata[7:0] == o_m_axis_tdata[15:8] &&
         o_m_axis_tdata[7:0] == o_m_axis_tdata[23:16]))
        else $error("gray colours differ");

endmodule

`default_nettype wire

### tb/sv/pixel_point_check.sv
`timescale 1ns / 1ps

// watches the config port and both streams, predicts each result pixel and compares
module pixel_point_check (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_addr,
    input  wire logic [17:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    // chan0_in[7:0], chan1_in[15:8], chan2_in[23:16], alpha_in[31:24]
    input  wire logic [31:0] i_s_axis_tdata,
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // chan0_out[7:0], chan1_out[15:8], chan2_out[23:16], alpha_out[31:24]
    input  wire logic [31:0] i_m_axis_tdata,
    output int               o_fail_count,
    output int               o_pending
);
    import ppo_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] c2;
        logic [CHAN_W-1:0] c1;
        logic [CHAN_W-1:0] c0;
    } t_pixel;

    logic [MODE_W-1:0]         shadow_mode;
    logic signed [PARAM_W-1:0] shadow_param;
    t_pixel                    expected_pixels[$];
    int                        fail_count;
    int                        pending_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // q.8 value truncated toward zero, then saturated to one byte
    function automatic logic [CHAN_W-1:0] saturate_q8(longint v);
        longint r;
        if (v <= 0) begin
            return '0;
        end
        r = v / 256;
        if (r > 255) begin
            return CHAN_MAX;
        end
        return r[CHAN_W-1:0];
    endfunction

    function automatic t_pixel point_op(t_pixel px, logic [MODE_W-1:0] op,
                                        logic signed [PARAM_W-1:0] param);
        t_pixel            r;
        longint            p;
        logic [SUM_W-1:0]  sum;
        logic [CHAN_W-1:0] avg;
        longint            thr;
        r   = px;
        p   = param;
        sum = SUM_W'(px.c0) + SUM_W'(px.c1) + SUM_W'(px.c2);
        avg = CHAN_W'(sum / 3);
        case (op)
            MODE_ADD: begin
                r.c0 = saturate_q8(longint'(px.c0) * 256 + p);
                r.c1 = saturate_q8(longint'(px.c1) * 256 + p);
                r.c2 = saturate_q8(longint'(px.c2) * 256 + p);
            end
            MODE_GAIN: begin
                r.c0 = saturate_q8(longint'(px.c0) * p);
                r.c1 = saturate_q8(longint'(px.c1) * p);
                r.c2 = saturate_q8(longint'(px.c2) * p);
            end
            MODE_G2A: begin
                r.alpha = avg;
            end
            MODE_GRAY: begin
                r.c0 = avg;
                r.c1 = avg;
                r.c2 = avg;
            end
            MODE_THR: begin
                // integer part, truncated toward zero
                thr  = p / 256;
                r.c0 = (longint'(avg) > thr) ? CHAN_MAX : '0;
                r.c1 = r.c0;
                r.c2 = r.c0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // config shadow, prediction on input request, compare on output request
    always @(posedge i_clk) begin
        t_pixel want;
        t_pixel got;
        if (!i_rst_n) begin
            shadow_mode   = MODE_PASS;
            shadow_param  = '0;
            expected_pixels.delete();
            pending_count = 0;
            fail_count    = 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == CFG_MODE) begin
                    shadow_mode = i_cfg_data[MODE_W-1:0];
                end else begin
                    shadow_param = i_cfg_data;
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_pixels.push_back(point_op(i_s_axis_tdata, shadow_mode, shadow_param));
                pending_count++;
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result pixel %h", got);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    pending_count--;
                    if (got.c0 !== want.c0) begin
                        $error("chan0_out: expected %0d, actual %0d", want.c0, got.c0);
                        fail_count++;
                    end
                    if (got.c1 !== want.c1) begin
                        $error("chan1_out: expected %0d, actual %0d", want.c1, got.c1);
                        fail_count++;
                    end
                    if (got.c2 !== want.c2) begin
                        $error("chan2_out: expected %0d, actual %0d", want.c2, got.c2);
                        fail_count++;
                    end
                    if (got.alpha !== want.alpha) begin
                        $error("alpha_out: expected %0d, actual %0d", want.alpha, got.alpha);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### tb/sv/tb_pixel_point_operation.sv
`timescale 1ns / 1ps

module tb_pixel_point_operation;
    import ppo_pkg::*;

    // mode codes with no operation of their own
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    localparam int RANDOM_PIXELS = 1400;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 4;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic        i_cfg_addr      = 1'b0;
    logic [17:0] i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // chan0_in[7:0], chan1_in[15:8], chan2_in[23:16], alpha_in[31:24]
    logic [31:0] i_s_axis_tdata  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // chan0_out[7:0], chan1_out[15:8], chan2_out[23:16], alpha_out[31:24]
    logic [31:0] o_m_axis_tdata;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    int src_burst    = 0;
    int snk_burst    = 0;

    pixel_point_operation dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    pixel_point_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // idle cycles before the next request, with runs of back-to-back requests
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(10, 40);
        end
        return $urandom_range(0, 12);
    endfunction

    // parameter mix: random values, extremes, small gains, offsets and whole thresholds
    function automatic logic [17:0] pick_param();
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = -131072;
            2: v = 131071;
            3: v = int'($urandom_range(0, 1023)) - 512;
            4: v = (int'($urandom_range(0, 600)) - 300) * 256 + int'($urandom_range(0, 255));
            default: v = int'($urandom_range(0, 255)) * 256;
        endcase
        return v[17:0];
    endfunction

    // called at the edge of the previous request, returns at the edge of this one
    task automatic send_pixel(input logic [31:0] px);
        int gap;
        gap = draw_gap(src_burst);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // wait until every result is back, then let the pipeline drain
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_cfg(input logic [MODE_W-1:0] op, input logic [17:0] param);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= CFG_MODE;
        i_cfg_data  <= 18'(op);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_PARAM;
        i_cfg_data  <= param;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic directed_phase(input logic [MODE_W-1:0] op, input logic [17:0] param);
        wait_idle();
        apply_cfg(op, param);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
    endtask

    // result sink with random back-pressure
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = draw_gap(snk_burst);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // watchdog on cycles with no request on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial begin
        int sent;
        int phase_len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: pass-through
        send_pixel(32'h0000_0000);
        send_pixel(32'h7F80_01FE);

        // saturation, clamping to zero and fractional truncation, then gray to alpha and gray
        directed_phase(MODE_ADD, 18'h1FFFF);
        directed_phase(MODE_ADD, 18'h20000);
        directed_phase(MODE_ADD, 18'h3FE80);
        directed_phase(MODE_GAIN, 18'h1FFFF);
        directed_phase(MODE_GAIN, 18'h20000);
        directed_phase(MODE_GAIN, 18'h00080);
        directed_phase(MODE_G2A, 18'h00000);
        wait_idle();
        apply_cfg(MODE_GRAY, 18'h00000);
        send_pixel(32'hA5FE_017F);
        send_pixel(32'hFFFF_FFFF);
        // negative threshold and threshold at the top of the range, then pass-through and spare modes
        directed_phase(MODE_THR, 18'h3FB00);
        directed_phase(MODE_THR, 18'h0FF00);
        directed_phase(MODE_PASS, 18'h3FFFF);
        wait_idle();
        apply_cfg(MODE_SPARE6, 18'h12345);
        send_pixel(32'h1234_ABCD);
        wait_idle();
        apply_cfg(MODE_SPARE7, 18'h2A5A5);
        send_pixel(32'hFEDC_5432);

        // random pixels under random settings
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            wait_idle();
            apply_cfg(MODE_W'($urandom_range(0, 7)), pick_param());
            phase_len = $urandom_range(60, 140);
            repeat (phase_len) begin
                send_pixel($urandom);
                sent++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### pixel_point_operation.f
rtl/ppo_pkg.sv
rtl/ppo_lane.sv
rtl/ppo_gray.sv
rtl/pixel_point_operation.sv
tb/sv/pixel_point_check.sv
tb/sv/tb_pixel_point_operation.sv
